// File: sv/b64sc_pkg.sv
// Shared types, codes and character tables for the Base64 stream codec.
package b64sc_pkg;

    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed
    {
        logic [7:0] in_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // One closed group as handed from the front end to the emitter.
    typedef struct packed
    {
        logic [23:0] bits;
        logic [1:0]  count;   // items in the group, minus one
        mode_t       mode;
        logic        last;
    } group_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] wide;
        begin
            wide = {2'b00, v};
            if (v < 6'd26)
            begin
                enc_char = wide + 8'd65;
            end
            else if (v < 6'd52)
            begin
                enc_char = wide + 8'd71;
            end
            else if (v < 6'd62)
            begin
                enc_char = wide - 8'd4;
            end
            else if (v == 6'd62)
            begin
                enc_char = 8'h2B;
            end
            else
            begin
                enc_char = 8'h2F;
            end
        end
    endfunction

    // Pad and foreign characters decode as zero.
    function automatic logic [5:0] dec_value(input logic [7:0] c);
        logic [7:0] wide;
        begin
            wide = 8'd0;
            if (c >= 8'h41 && c <= 8'h5A)
            begin
                wide = c - 8'd65;
            end
            else if (c >= 8'h61 && c <= 8'h7A)
            begin
                wide = c - 8'd71;
            end
            else if (c >= 8'h30 && c <= 8'h39)
            begin
                wide = c + 8'd4;
            end
            else if (c == 8'h2B)
            begin
                wide = 8'd62;
            end
            else if (c == 8'h2F)
            begin
                wide = 8'd63;
            end
            dec_value = wide[5:0];
        end
    endfunction

endpackage

// File: sv/b64sc_front.sv
// Front end: mode register, input acceptance and group gathering.
module b64sc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  b64sc_pkg::in_item_t in_data,
    output logic                push_valid,
    input  logic                push_ready,
    output b64sc_pkg::group_t   push_data
);

    b64sc_pkg::mode_t mode_reg;
    b64sc_pkg::mode_t mode_next;
    logic [23:0]      bits_reg;
    logic [23:0]      bits_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic [23:0]      bits_merged;
    logic [5:0]       char_val;
    logic             closes;
    logic             accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = push_ready;
    assign accept    = in_valid && in_ready;
    assign char_val  = b64sc_pkg::dec_value(in_data.in_byte);

    always_comb
    begin
        bits_merged = bits_reg;
        closes      = 1'b0;
        if (mode_reg == b64sc_pkg::MODE_ENCODE)
        begin
            case (count_reg)
                2'd0:    bits_merged = bits_reg | {in_data.in_byte, 16'h0000};
                2'd1:    bits_merged = bits_reg | {8'h00, in_data.in_byte, 8'h00};
                2'd2:    bits_merged = bits_reg | {16'h0000, in_data.in_byte};
                default: bits_merged = bits_reg;
            endcase
            closes = in_data.is_last || (count_reg == 2'd2);
        end
        else
        begin
            case (count_reg)
                2'd0:    bits_merged = bits_reg | {char_val, 18'h00000};
                2'd1:    bits_merged = bits_reg | {6'h00, char_val, 12'h000};
                2'd2:    bits_merged = bits_reg | {12'h000, char_val, 6'h00};
                default: bits_merged = bits_reg | {18'h00000, char_val};
            endcase
            closes = in_data.is_last || (count_reg == 2'd3);
        end
    end

    assign push_valid      = accept && closes;
    assign push_data.bits  = bits_merged;
    assign push_data.count = count_reg;
    assign push_data.mode  = mode_reg;
    assign push_data.last  = in_data.is_last;

    always_comb
    begin
        mode_next  = mode_reg;
        bits_next  = bits_reg;
        count_next = count_reg;
        if (cfg_valid && cfg_ready)
        begin
            // A mode write throws away any partly gathered group.
            mode_next  = b64sc_pkg::mode_t'(cfg_data);
            bits_next  = 24'h000000;
            count_next = 2'd0;
        end
        else if (accept)
        begin
            if (closes)
            begin
                bits_next  = 24'h000000;
                count_next = 2'd0;
            end
            else
            begin
                bits_next  = bits_merged;
                count_next = count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= b64sc_pkg::MODE_ENCODE;
            bits_reg  <= 24'h000000;
            count_reg <= 2'd0;
        end
        else
        begin
            mode_reg  <= mode_next;
            bits_reg  <= bits_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/b64sc_queue.sv
// Small queue of closed groups between the front end and the emitter.
module b64sc_queue
#(
    parameter int DEPTH = b64sc_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  b64sc_pkg::group_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output b64sc_pkg::group_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64sc_pkg::group_t entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/b64sc_back.sv
// Emitter: unpacks a group to characters or bytes, one per unstalled cycle.
module b64sc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  b64sc_pkg::group_t    pop_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output b64sc_pkg::out_item_t out_data
);

    b64sc_pkg::group_t    group_reg;
    logic                 busy_reg;
    logic                 busy_next;
    logic [1:0]           step_reg;
    logic [1:0]           step_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    b64sc_pkg::out_item_t out_data_reg;
    b64sc_pkg::out_item_t result;
    logic [5:0]           sextet;
    logic                 load;
    logic                 final_step;
    logic                 is_pad;

    assign load       = busy_reg && (!out_valid_reg || out_ready);
    assign final_step = (group_reg.mode == b64sc_pkg::MODE_DECODE) ? (step_reg == 2'd2)
                                                                   : (step_reg == 2'd3);
    assign pop_ready  = !busy_reg || (load && final_step);

    // In encode mode a character is padding when its place lies beyond the
    // number of bytes the group holds.
    assign is_pad = ({1'b0, step_reg} > ({1'b0, group_reg.count} + 3'd1));

    always_comb
    begin
        case (step_reg)
            2'd0:    sextet = group_reg.bits[23:18];
            2'd1:    sextet = group_reg.bits[17:12];
            2'd2:    sextet = group_reg.bits[11:6];
            default: sextet = group_reg.bits[5:0];
        endcase
        result.out_last = group_reg.last;
        if (group_reg.mode == b64sc_pkg::MODE_ENCODE)
        begin
            result.out_byte = is_pad ? b64sc_pkg::PAD_CHAR : b64sc_pkg::enc_char(sextet);
        end
        else
        begin
            case (step_reg)
                2'd0:    result.out_byte = group_reg.bits[23:16];
                2'd1:    result.out_byte = group_reg.bits[15:8];
                default: result.out_byte = group_reg.bits[7:0];
            endcase
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (pop_valid && pop_ready)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end
        else if (load && final_step)
        begin
            busy_next = 1'b0;
        end
        else if (load)
        begin
            step_next = step_reg + 2'd1;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            group_reg <= pop_data;
        end
        if (load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: sv/base64_stream_codec.sv
// Top level of the streaming Base64 encoder and decoder.
//
//   channel  direction  carries
//   cfg      in         mode bit, 0 encodes, 1 decodes
//   in       in         one byte or character and its end-of-message flag
//   out      out        one character or byte and its end-of-message flag
//
// An input transaction is taken every cycle while the group queue has room.
// A closed group leaves four characters (encode) or three bytes (decode), one per cycle
// from the emitter while the output is not stalled, through the queue and the emitter's
// group and output registers. Sustained encode throughput is set by the emitter.
// Reset clears the mode to encode and empties the queue; no clearing pass.
// A stalled output holds the emitter; the queue of QUEUE_DEPTH groups keeps input moving.
module base64_stream_codec
#(
    parameter int QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  b64sc_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output b64sc_pkg::out_item_t out_data
);

    logic              push_valid;
    logic              push_ready;
    b64sc_pkg::group_t push_data;
    logic              pop_valid;
    logic              pop_ready;
    b64sc_pkg::group_t pop_data;

    b64sc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    b64sc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b64sc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: sv/b64sc_checker.sv
// Port-level checks for the Base64 stream codec, bound to the top level.
module b64sc_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic                 cfg_data,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input b64sc_pkg::out_item_t out_data
);

    logic mode_reg;
    logic seen_in_reg;
    logic [7:0] ch;

    assign ch = out_data.out_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            seen_in_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (in_valid && in_ready)
            begin
                seen_in_reg <= 1'b1;
            end
        end
    end

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write not taken at once");

    // While encoding, only alphabet characters and padding come out.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mode_reg |->
            (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
            (ch >= 8'h30 && ch <= 8'h39) || ch == 8'h2B || ch == 8'h2F || ch == 8'h3D)
        else $error("encoder produced a character outside the alphabet");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_in_reg)
        else $error("result appeared before any input transaction");

endmodule

bind base64_stream_codec b64sc_checker u_b64sc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
